FILE: src/lras_pkg.sv
// Package for the line rasterizer: coordinate widths, register index codes
// and input mode codes. No dependencies.
`timescale 1ns / 1ps

package lras_pkg;

  localparam int COORD_BITS = 12;              // endpoint and pixel coordinate width
  localparam int DELTA_BITS = COORD_BITS + 1;  // axis deltas, differences
  localparam int ERR_BITS   = COORD_BITS + 2;  // signed error accumulator
  localparam int CLIP_BITS  = 11;              // clip window registers
  localparam int COLOR_BITS = 24;
  localparam int CFG_IDX_BITS = 2;
  // compare width that holds both a signed coordinate and an unsigned clip value
  localparam int CMP_BITS = ((COORD_BITS > CLIP_BITS) ? COORD_BITS : CLIP_BITS) + 1;

  localparam logic [CLIP_BITS-1:0] CLIP_WIDTH_RESET  = CLIP_BITS'(127);
  localparam logic [CLIP_BITS-1:0] CLIP_HEIGHT_RESET = CLIP_BITS'(159);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CLIP_WIDTH  = 2'd0,
    REG_CLIP_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef enum logic {
    MODE_LOAD    = 1'b0,
    MODE_ADVANCE = 1'b1
  } mode_e;

endpackage

FILE: src/line_rasterizer.sv
// Top level of the Bresenham line rasterizer with clip flags.
// Depends on lras_pkg.
`timescale 1ns / 1ps

// Channel   Dir  Handshake                     Word
// -------   ---  ----------------------------  -------------------------------------
// in        in   in_valid_i / in_stall_o       mode, two endpoints, line color
// out       out  out_valid_o / out_stall_i     pixel x/y, color, on_screen, last, valid
// cfg       in   cfg_valid_i / cfg_ready_o     register index, clip value
//
// One word in, one word out, one word per clock sustained while the output is
// not stalled. A word passes an input register, then the setup/step logic (a
// subtract and compare chain over 13- and 14-bit values) into the output register.
// Reset clears the handshake state, the line state (no line active) and sets
// the clip window to 127 x 159. The config port is always ready.
// A stalled output only backs up the input register; an input word is taken
// as long as that register can move on in the same cycle.

module line_rasterizer
  import lras_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,

  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         mode_i,
  input  logic signed [COORD_BITS-1:0] x_start_i,
  input  logic signed [COORD_BITS-1:0] y_start_i,
  input  logic signed [COORD_BITS-1:0] x_end_i,
  input  logic signed [COORD_BITS-1:0] y_end_i,
  input  logic        [COLOR_BITS-1:0] line_color_i,

  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [COORD_BITS-1:0] pixel_x_o,
  output logic signed [COORD_BITS-1:0] pixel_y_o,
  output logic        [COLOR_BITS-1:0] pixel_color_o,
  output logic                         on_screen_o,
  output logic                         last_pixel_o,
  output logic                         pixel_valid_o,

  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic      [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic         [CLIP_BITS-1:0] cfg_data_i
);

  // ---------------------------------------------------------------- config
  logic [CLIP_BITS-1:0] clip_w_q, clip_h_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_w_q <= CLIP_WIDTH_RESET;
      clip_h_q <= CLIP_HEIGHT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_CLIP_WIDTH:  clip_w_q <= cfg_data_i;
        REG_CLIP_HEIGHT: clip_h_q <= cfg_data_i;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // ---------------------------------------------------------------- handshake
  logic in_v_q, in_v_d, out_v_q, out_v_d;
  logic fire, accept;

  // input register moves on when the output register is free or draining
  assign fire       = in_v_q && !(out_v_q && out_stall_i);
  assign in_stall_o = in_v_q && out_v_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_v_d = in_v_q;
    if (accept)    in_v_d = 1'b1;
    else if (fire) in_v_d = 1'b0;
    out_v_d = out_v_q;
    if (fire)                         out_v_d = 1'b1;
    else if (out_v_q && !out_stall_i) out_v_d = 1'b0;
  end

  // ---------------------------------------------------------------- input register
  logic                         mode_q;
  logic signed [COORD_BITS-1:0] x0_q, y0_q, x1_q, y1_q;
  logic        [COLOR_BITS-1:0] color_in_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q     <= mode_i;
      x0_q       <= x_start_i;
      y0_q       <= y_start_i;
      x1_q       <= x_end_i;
      y1_q       <= y_end_i;
      color_in_q <= line_color_i;
    end
  end

  // ---------------------------------------------------------------- line state
  logic                         steep_q, down_q, active_q;
  logic signed [COORD_BITS-1:0] major_q, minor_q, end_q;
  logic        [DELTA_BITS-1:0] delta_q, mdelta_q;
  logic signed   [ERR_BITS-1:0] err_q;
  logic        [COLOR_BITS-1:0] color_q;

  // load setup: pick major axis, order endpoints
  logic signed [DELTA_BITS-1:0] dx, dy, db;
  logic        [DELTA_BITS-1:0] adx, ady;
  logic signed [COORD_BITS-1:0] a0, b0, a1, b1, sa0, sb0, sa1, sb1;
  logic                         ld_steep;
  logic        [DELTA_BITS-1:0] ld_delta, ld_mdelta;

  always_comb begin
    dx  = DELTA_BITS'(x1_q) - DELTA_BITS'(x0_q);
    dy  = DELTA_BITS'(y1_q) - DELTA_BITS'(y0_q);
    adx = dx[DELTA_BITS-1] ? DELTA_BITS'(-dx) : DELTA_BITS'(dx);
    ady = dy[DELTA_BITS-1] ? DELTA_BITS'(-dy) : DELTA_BITS'(dy);
    ld_steep = ady > adx;
    if (ld_steep) begin
      a0 = y0_q; b0 = x0_q; a1 = y1_q; b1 = x1_q;
    end else begin
      a0 = x0_q; b0 = y0_q; a1 = x1_q; b1 = y1_q;
    end
    if (a0 > a1) begin
      sa0 = a1; sb0 = b1; sa1 = a0; sb1 = b0;
    end else begin
      sa0 = a0; sb0 = b0; sa1 = a1; sb1 = b1;
    end
    ld_delta  = DELTA_BITS'(DELTA_BITS'(sa1) - DELTA_BITS'(sa0));
    db        = DELTA_BITS'(sb1) - DELTA_BITS'(sb0);
    ld_mdelta = db[DELTA_BITS-1] ? DELTA_BITS'(-db) : DELTA_BITS'(db);
  end

  // current line: freshly loaded or held state
  logic                         is_load, emit;
  logic                         cur_steep, cur_down;
  logic signed [COORD_BITS-1:0] cur_major, cur_minor, cur_end;
  logic        [DELTA_BITS-1:0] cur_delta, cur_mdelta;
  logic signed   [ERR_BITS-1:0] cur_err;
  logic        [COLOR_BITS-1:0] cur_color;

  assign is_load = (mode_q == MODE_LOAD);
  assign emit    = is_load || active_q;

  always_comb begin
    if (is_load) begin
      cur_steep  = ld_steep;
      cur_major  = sa0;
      cur_minor  = sb0;
      cur_end    = sa1;
      cur_delta  = ld_delta;
      cur_mdelta = ld_mdelta;
      cur_err    = ERR_BITS'(ld_delta >> 1);
      cur_down   = !(sb0 < sb1);
      cur_color  = color_in_q;
    end else begin
      cur_steep  = steep_q;
      cur_major  = major_q;
      cur_minor  = minor_q;
      cur_end    = end_q;
      cur_delta  = delta_q;
      cur_mdelta = mdelta_q;
      cur_err    = err_q;
      cur_down   = down_q;
      cur_color  = color_q;
    end
  end

  // emit the current pixel, then step
  logic signed [COORD_BITS-1:0] px, py;
  logic signed   [CMP_BITS-1:0] px_c, py_c, cw_c, ch_c;
  logic                         on, last;
  logic signed   [ERR_BITS-1:0] err_sub, err_nxt;
  logic signed [COORD_BITS-1:0] minor_nxt, major_nxt;

  always_comb begin
    px   = cur_steep ? cur_minor : cur_major;
    py   = cur_steep ? cur_major : cur_minor;
    px_c = CMP_BITS'(px);
    py_c = CMP_BITS'(py);
    cw_c = $signed(CMP_BITS'(clip_w_q));
    ch_c = $signed(CMP_BITS'(clip_h_q));
    on   = !px[COORD_BITS-1] && !py[COORD_BITS-1] && (px_c < cw_c) && (py_c < ch_c);
    last = cur_major >= cur_end;

    err_sub   = cur_err - $signed(ERR_BITS'(cur_mdelta));
    err_nxt   = err_sub;
    minor_nxt = cur_minor;
    if (err_sub[ERR_BITS-1]) begin
      minor_nxt = cur_down ? cur_minor - COORD_BITS'(1) : cur_minor + COORD_BITS'(1);
      err_nxt   = err_sub + $signed(ERR_BITS'(cur_delta));
    end
    major_nxt = cur_major + COORD_BITS'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steep_q  <= 1'b0;
      down_q   <= 1'b0;
      active_q <= 1'b0;
      major_q  <= '0;
      minor_q  <= '0;
      end_q    <= '0;
      delta_q  <= '0;
      mdelta_q <= '0;
      err_q    <= '0;
      color_q  <= '0;
    end else if (fire && emit) begin
      steep_q  <= cur_steep;
      down_q   <= cur_down;
      end_q    <= cur_end;
      delta_q  <= cur_delta;
      mdelta_q <= cur_mdelta;
      color_q  <= cur_color;
      active_q <= !last;
      // the final pixel leaves the position where it is
      major_q  <= last ? cur_major : major_nxt;
      minor_q  <= last ? cur_minor : minor_nxt;
      err_q    <= last ? cur_err   : err_nxt;
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      in_v_q  <= in_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      // advance with no line: all-zero word, pixel_valid low
      pixel_x_o     <= emit ? px        : '0;
      pixel_y_o     <= emit ? py        : '0;
      pixel_color_o <= emit ? cur_color : '0;
      on_screen_o   <= emit && on;
      last_pixel_o  <= emit && last;
      pixel_valid_o <= emit;
    end
  end

  assign out_valid_o = out_v_q;

endmodule

FILE: src/lras_checker.sv
// Port-level checks for line_rasterizer, attached by bind.
// Depends on lras_pkg.
`timescale 1ns / 1ps

module lras_checker
  import lras_pkg::*;
(
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic signed [COORD_BITS-1:0] pixel_x_o,
  input logic signed [COORD_BITS-1:0] pixel_y_o,
  input logic        [COLOR_BITS-1:0] pixel_color_o,
  input logic                         on_screen_o,
  input logic                         last_pixel_o,
  input logic                         pixel_valid_o
);

  // stalled output keeps valid, position, color and last flag
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_x_o) &&
      $stable(pixel_y_o) && $stable(pixel_color_o) && $stable(last_pixel_o))
    else $error("output word changed while stalled");

  // idle advance gives an all-zero word
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pixel_valid_o |-> pixel_x_o == '0 && pixel_y_o == '0 &&
      pixel_color_o == '0 && !on_screen_o && !last_pixel_o)
    else $error("idle word not zero");

  // on-screen pixels have nonnegative coordinates
  a_on_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && on_screen_o |-> pixel_valid_o &&
      !pixel_x_o[COORD_BITS-1] && !pixel_y_o[COORD_BITS-1])
    else $error("on_screen with negative coordinate");

  // last flag only on a real pixel
  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_pixel_o |-> pixel_valid_o)
    else $error("last_pixel without pixel_valid");

endmodule

bind line_rasterizer lras_checker u_lras_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .pixel_x_o     (pixel_x_o),
  .pixel_y_o     (pixel_y_o),
  .pixel_color_o (pixel_color_o),
  .on_screen_o   (on_screen_o),
  .last_pixel_o  (last_pixel_o),
  .pixel_valid_o (pixel_valid_o)
);
